// File: hw/rtl/fmcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmcp_pkg
// Shared types, constants and the control store of the feeder motor cascade
// proportional controller.
// ----------------------------------------------------------------------------
package fmcp_pkg;

    localparam int AVG_TAPS_DEF   = 5;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int UPC_W      = 4;

    localparam int SAMPLE_W = 21;
    localparam int AVG_W    = 24;
    localparam int PULSE_W  = 32;
    localparam int DRIVE_W  = 10;

    // Reciprocals for exact floor division by 13 and by 125.
    localparam logic [28:0] RECIP_13  = 29'd330382100;
    localparam logic [17:0] RECIP_125 = 18'd134218;

    localparam logic [9:0]  DRIVE_MAX      = 10'd600;
    localparam logic [9:0]  DRIVE_ERROR    = 10'd350;
    localparam logic [8:0]  SETPOINT_MAX   = 9'd256;
    localparam logic [19:0] OUTER_PROD_SAT = 20'd1000;
    localparam logic [23:0] LAG_LIMIT      = 24'd256;

    localparam logic [9:0]  OUTER_GAIN_RST  = 10'd180;
    localparam logic [7:0]  INNER_GAIN_RST  = 8'd35;
    localparam logic [23:0] STALL_MIN_RST   = 24'd256;
    localparam logic [15:0] STALL_LIMIT_RST = 16'd100;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_STEP  = 2'd1,
        OP_STALL = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTER_GAIN  = 3'd0,
        CFG_INNER_GAIN  = 3'd1,
        CFG_STALL_MIN   = 3'd2,
        CFG_STALL_LIMIT = 3'd3,
        CFG_ERR_CHECK   = 3'd4,
        CFG_ERR_DRIVE   = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        UOP_NOP        = 4'd0,
        UOP_SAMPLE_MUL = 4'd1,
        UOP_RING_UPD   = 4'd2,
        UOP_AVG_MUL    = 4'd3,
        UOP_AVG_SET    = 4'd4,
        UOP_POS_SET    = 4'd5,
        UOP_POS_DELTA  = 4'd6,
        UOP_SPD_DELTA  = 4'd7,
        UOP_DRV_MUL    = 4'd8,
        UOP_DRV_SET    = 4'd9,
        UOP_STEP_GOAL  = 4'd10,
        UOP_STALL      = 4'd11,
        UOP_ERR_DRIVE  = 4'd12,
        UOP_EMIT       = 4'd13
    } t_uop;

    typedef enum logic [1:0] {
        JC_NEXT     = 2'd0,
        JC_GOTO     = 2'd1,
        JC_IF_SPEED = 2'd2
    } t_jcond;

    typedef struct packed {
        t_uop              uop;
        t_jcond            jc;
        logic [UPC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic [9:0]  outer_gain;
        logic [7:0]  inner_gain;
        logic [23:0] stall_speed_min;
        logic [15:0] stall_limit;
        logic        err_check_en;
        logic        err_drive_en;
    } t_cfg;

    typedef struct packed {
        logic load;
        t_uop uop;
    } t_dp_ctrl;

    typedef struct packed {
        logic pos_mode;
        logic err_latch;
    } t_dp_stat;

    localparam logic [UPC_W-1:0] UA_TICK      = 4'd0;
    localparam logic [UPC_W-1:0] UA_SPEED     = 4'd6;
    localparam logic [UPC_W-1:0] UA_DRIVE_MUL = 4'd7;
    localparam logic [UPC_W-1:0] UA_STEP      = 4'd9;
    localparam logic [UPC_W-1:0] UA_STALL     = 4'd10;
    localparam logic [UPC_W-1:0] UA_ERR       = 4'd11;
    localparam logic [UPC_W-1:0] UA_EMIT      = 4'd12;

    function automatic t_uword ucode_rom(input logic [UPC_W-1:0] addr);
        t_uword w;
        w = '{uop: UOP_EMIT, jc: JC_NEXT, target: UA_EMIT};
        unique case (addr)
            4'd0:  w = '{uop: UOP_SAMPLE_MUL, jc: JC_NEXT,     target: UA_EMIT};
            4'd1:  w = '{uop: UOP_RING_UPD,   jc: JC_NEXT,     target: UA_EMIT};
            4'd2:  w = '{uop: UOP_AVG_MUL,    jc: JC_NEXT,     target: UA_EMIT};
            4'd3:  w = '{uop: UOP_AVG_SET,    jc: JC_IF_SPEED, target: UA_SPEED};
            4'd4:  w = '{uop: UOP_POS_SET,    jc: JC_NEXT,     target: UA_EMIT};
            4'd5:  w = '{uop: UOP_POS_DELTA,  jc: JC_GOTO,     target: UA_DRIVE_MUL};
            4'd6:  w = '{uop: UOP_SPD_DELTA,  jc: JC_NEXT,     target: UA_EMIT};
            4'd7:  w = '{uop: UOP_DRV_MUL,    jc: JC_NEXT,     target: UA_EMIT};
            4'd8:  w = '{uop: UOP_DRV_SET,    jc: JC_GOTO,     target: UA_EMIT};
            4'd9:  w = '{uop: UOP_STEP_GOAL,  jc: JC_GOTO,     target: UA_EMIT};
            4'd10: w = '{uop: UOP_STALL,      jc: JC_GOTO,     target: UA_EMIT};
            4'd11: w = '{uop: UOP_ERR_DRIVE,  jc: JC_GOTO,     target: UA_EMIT};
            default: w = '{uop: UOP_EMIT,     jc: JC_NEXT,     target: UA_EMIT};
        endcase
        return w;
    endfunction

    function automatic logic [UPC_W-1:0] entry_addr(input logic [1:0] op,
                                                    input logic err_hold);
        logic [UPC_W-1:0] a;
        a = UA_EMIT;
        unique case (op)
            OP_TICK:  a = err_hold ? UA_ERR : UA_TICK;
            OP_STEP:  a = UA_STEP;
            OP_STALL: a = UA_STALL;
            default:  a = UA_EMIT;
        endcase
        return a;
    endfunction

endpackage

// File: hw/rtl/fmcp_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmcp_dpath
// Controller datapath: speed ring, pulse counters, stall logic and one shared
// multiplier, all driven by the micro-operation of the current step.
// ----------------------------------------------------------------------------
module fmcp_dpath #(
    parameter int AVG_TAPS   = fmcp_pkg::AVG_TAPS_DEF,
    parameter int COUNT_BITS = fmcp_pkg::COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fmcp_pkg::t_dp_ctrl   i_ctrl,
    input  fmcp_pkg::t_cfg       i_cfg,
    input  logic signed [15:0]   i_encoder_delta,
    input  logic                 i_position_mode,
    input  logic [23:0]          i_speed_target,
    input  logic                 i_load_command,
    input  logic                 i_mouse_left,
    input  logic                 i_switch_up,
    input  logic                 i_computer_mode,
    input  logic [15:0]          i_step_size,
    output fmcp_pkg::t_dp_stat   o_stat,
    output logic [9:0]           o_drive,
    output logic                 o_drive_written,
    output logic                 o_working_flag,
    output logic                 o_motor_error,
    output logic [23:0]          o_average_speed
);

    localparam int SAMPLE_W = fmcp_pkg::SAMPLE_W;
    localparam int SLOT_W   = $clog2(AVG_TAPS);
    localparam int SUM_W    = SAMPLE_W + $clog2(AVG_TAPS);
    localparam int MUL_A_W  = (SUM_W > 25) ? SUM_W : 25;
    localparam int MUL_B_W  = 32;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int CMP_W    = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [31:0] AVG_RECIP =
        32'(((64'd1 << 32) + 64'(AVG_TAPS) - 64'd1) / 64'(AVG_TAPS));
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(AVG_TAPS - 1);

    // Captured request.
    logic signed [15:0] r_enc;
    logic               r_pos_mode;
    logic [23:0]        r_target;
    logic               r_cmd;
    logic               r_ml;
    logic               r_sw;
    logic               r_cm;
    logic [15:0]        r_step;

    // Controller state.
    logic [SAMPLE_W-1:0]   r_ring [AVG_TAPS];
    logic [SLOT_W-1:0]     r_slot;
    logic [SUM_W-1:0]      r_sum;
    logic [23:0]           r_avg;
    logic [31:0]           r_pulse_count;
    logic [31:0]           r_pulse_goal;
    logic [COUNT_BITS-1:0] r_slow;
    logic                  r_err;
    logic                  r_working;
    logic [9:0]            r_drive;
    logic                  r_written;

    // Scratch registers.
    logic [PROD_W-1:0] r_prod;
    logic [23:0]       r_delta;
    logic              r_big;
    logic              r_err_pos;

    logic [15:0]          w_neg;
    logic [14:0]          w_abs;
    logic [24:0]          w_x;
    logic [SAMPLE_W-1:0]  w_sample;
    logic [23:0]          w_avg_q;
    logic [31:0]          w_perr;
    logic                 w_perr_pos;
    logic [9:0]           w_esat;
    logic [19:0]          w_outer_prod;
    logic [8:0]           w_set;
    logic [24:0]          w_pdiff;
    logic [24:0]          w_sdiff;
    logic                 w_lag;
    logic [10:0]          w_g5;
    logic                 w_drv_over;
    logic [9:0]           w_drv_clamp;
    logic                 w_gate;
    logic [COUNT_BITS-1:0] w_slow_next;
    logic [MUL_A_W-1:0]   w_mul_a;
    logic [MUL_B_W-1:0]   w_mul_b;

    assign w_neg = 16'(-r_enc);
    assign w_abs = r_enc[15] ? ((r_enc == 16'sh8000) ? 15'h7FFF : w_neg[14:0])
                             : r_enc[14:0];
    assign w_x   = (25'(w_abs) << 9) + (25'(w_abs) << 7);

    assign w_sample = r_prod[32 +: SAMPLE_W];
    assign w_avg_q  = r_prod[32 +: 24];

    assign w_perr     = r_pulse_goal - r_pulse_count;
    assign w_perr_pos = !w_perr[31] && (w_perr != 32'd0);
    assign w_esat     = (w_perr[31:10] != 22'd0) ? 10'h3FF : w_perr[9:0];
    assign w_outer_prod = r_prod[19:0];

    assign w_set   = !r_err_pos ? 9'd0
                   : (r_big ? fmcp_pkg::SETPOINT_MAX : {1'b0, r_prod[24 +: 8]});
    assign w_pdiff = {16'd0, w_set} - {1'b0, r_avg};
    assign w_sdiff = {1'b0, r_target} - {1'b0, r_avg};
    assign w_lag   = !w_sdiff[24] && (w_sdiff[23:0] > fmcp_pkg::LAG_LIMIT);

    assign w_g5 = 11'({i_cfg.inner_gain, 2'b00}) + 11'(i_cfg.inner_gain);

    assign w_drv_over  = r_prod[PROD_W-1:8] > (PROD_W - 8)'(fmcp_pkg::DRIVE_MAX);
    assign w_drv_clamp = w_drv_over ? fmcp_pkg::DRIVE_MAX : r_prod[17:8];
    assign w_gate      = r_pos_mode || (r_cm ? (r_cmd && r_ml) : (r_cmd && r_sw));

    always_comb begin
        if (r_avg < i_cfg.stall_speed_min) begin
            w_slow_next = (r_slow == {COUNT_BITS{1'b1}}) ? r_slow
                                                         : r_slow + COUNT_BITS'(1);
        end else begin
            w_slow_next = '0;
        end
    end

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_ctrl.uop)
            fmcp_pkg::UOP_SAMPLE_MUL: begin
                w_mul_a = MUL_A_W'(w_x);
                w_mul_b = MUL_B_W'(fmcp_pkg::RECIP_13);
            end
            fmcp_pkg::UOP_AVG_MUL: begin
                w_mul_a = MUL_A_W'(r_sum);
                w_mul_b = AVG_RECIP;
            end
            fmcp_pkg::UOP_AVG_SET: begin
                w_mul_a = MUL_A_W'(w_esat);
                w_mul_b = MUL_B_W'(i_cfg.outer_gain);
            end
            fmcp_pkg::UOP_POS_SET: begin
                w_mul_a = MUL_A_W'({w_outer_prod[9:0], 5'b00000});
                w_mul_b = MUL_B_W'(fmcp_pkg::RECIP_125);
            end
            fmcp_pkg::UOP_DRV_MUL: begin
                w_mul_a = MUL_A_W'(r_delta);
                w_mul_b = MUL_B_W'(w_g5);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
        if (i_ctrl.load) begin
            r_enc      <= i_encoder_delta;
            r_pos_mode <= i_position_mode;
            r_target   <= i_speed_target;
            r_cmd      <= i_load_command;
            r_ml       <= i_mouse_left;
            r_sw       <= i_switch_up;
            r_cm       <= i_computer_mode;
            r_step     <= i_step_size;
        end
        case (i_ctrl.uop)
            fmcp_pkg::UOP_AVG_SET: begin
                r_err_pos <= w_perr_pos;
            end
            fmcp_pkg::UOP_POS_SET: begin
                r_big <= w_outer_prod >= fmcp_pkg::OUTER_PROD_SAT;
            end
            fmcp_pkg::UOP_POS_DELTA: begin
                r_delta <= w_pdiff[24] ? 24'd0 : w_pdiff[23:0];
            end
            fmcp_pkg::UOP_SPD_DELTA: begin
                r_delta <= w_sdiff[24] ? 24'd0 : w_sdiff[23:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AVG_TAPS; i++) begin
                r_ring[i] <= '0;
            end
            r_slot        <= '0;
            r_sum         <= '0;
            r_avg         <= '0;
            r_pulse_count <= '0;
            r_pulse_goal  <= '0;
            r_slow        <= '0;
            r_err         <= 1'b0;
            r_working     <= 1'b1;
            r_drive       <= '0;
            r_written     <= 1'b0;
        end else begin
            if (i_ctrl.load) begin
                r_written <= 1'b0;
            end
            case (i_ctrl.uop)
                fmcp_pkg::UOP_RING_UPD: begin
                    r_ring[r_slot] <= w_sample;
                    r_sum  <= r_sum - SUM_W'(r_ring[r_slot]) + SUM_W'(w_sample);
                    r_slot <= (r_slot == SLOT_LAST) ? '0 : r_slot + SLOT_W'(1);
                    if (r_pos_mode) begin
                        r_pulse_count <= r_pulse_count + 32'(w_abs);
                    end
                end
                fmcp_pkg::UOP_AVG_SET: begin
                    r_avg <= w_avg_q;
                end
                fmcp_pkg::UOP_SPD_DELTA: begin
                    r_working <= !(w_lag && r_cmd && (r_ml || r_sw));
                end
                fmcp_pkg::UOP_DRV_SET: begin
                    r_drive   <= w_gate ? w_drv_clamp : 10'd0;
                    r_written <= 1'b1;
                end
                fmcp_pkg::UOP_STEP_GOAL: begin
                    r_pulse_count <= r_pulse_goal;
                    r_pulse_goal  <= r_pulse_goal + 32'(r_step);
                end
                fmcp_pkg::UOP_STALL: begin
                    if (CMP_W'(w_slow_next) >= CMP_W'(i_cfg.stall_limit)) begin
                        r_slow <= '0;
                        r_err  <= 1'b1;
                    end else begin
                        r_slow <= w_slow_next;
                    end
                end
                fmcp_pkg::UOP_ERR_DRIVE: begin
                    if (i_cfg.err_drive_en) begin
                        r_drive   <= fmcp_pkg::DRIVE_ERROR;
                        r_written <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.pos_mode  = r_pos_mode;
    assign o_stat.err_latch = r_err;
    assign o_drive          = r_drive;
    assign o_drive_written  = r_written;
    assign o_working_flag   = r_working;
    assign o_motor_error    = r_err;
    assign o_average_speed  = r_avg;

endmodule

// File: hw/rtl/feeder_motor_cascade_p_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feeder_motor_cascade_p_control
// Feeder motor cascade proportional controller with a microcoded sequencer.
//
// A request enters on i_valid/o_ready and carries an op: a control tick, a
// position step or a stall check. Each request yields one result on
// o_valid/i_ready with the drive value, whether this request wrote it, the
// working flag, the latched motor error and the averaged Q8 speed.
// The sequencer takes one request at a time and steps through a control
// store; each step drives the datapath around one shared multiplier.
// A control tick runs nine steps in position mode and eight in speed mode.
// A position step, a stall check and a tick held off by a latched error run
// two steps, an unused op one. The next request can be accepted in the cycle
// after the result is loaded. The result sits in an output register, so a new
// request can be accepted while a result waits; when the receiver stalls, the
// final step holds until the output register is free. Configuration writes on
// i_cfg_we take effect at once; the user must make them only while the block
// is idle, as the block itself does not enforce this.
// Reset is synchronous and clears the speed ring, counters, error latch and
// drive, sets the working flag and loads the register reset values.
// ----------------------------------------------------------------------------
module feeder_motor_cascade_p_control #(
    parameter int AVG_TAPS   = fmcp_pkg::AVG_TAPS_DEF,
    parameter int COUNT_BITS = fmcp_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fmcp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fmcp_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_op,
    input  logic signed [15:0]              i_encoder_delta,
    input  logic                            i_position_mode,
    input  logic [23:0]                     i_speed_target,
    input  logic                            i_load_command,
    input  logic                            i_mouse_left,
    input  logic                            i_switch_up,
    input  logic                            i_computer_mode,
    input  logic [15:0]                     i_step_size,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [9:0]                      o_drive,
    output logic                            o_drive_written,
    output logic                            o_working_flag,
    output logic                            o_motor_error,
    output logic [23:0]                     o_average_speed
);

    localparam int UPC_W = fmcp_pkg::UPC_W;

    fmcp_pkg::t_cfg     r_cfg;
    fmcp_pkg::t_dp_ctrl w_ctrl;
    fmcp_pkg::t_dp_stat w_stat;
    fmcp_pkg::t_uword   w_uword;

    logic             r_busy;
    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    logic             w_accept;
    logic             w_emit;
    logic             w_out_free;

    logic [9:0]  w_drive;
    logic        w_written;
    logic        w_working;
    logic        w_error;
    logic [23:0] w_avg;

    logic        r_out_valid;
    logic [9:0]  r_out_drive;
    logic        r_out_written;
    logic        r_out_working;
    logic        r_out_error;
    logic [23:0] r_out_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.outer_gain      <= fmcp_pkg::OUTER_GAIN_RST;
            r_cfg.inner_gain      <= fmcp_pkg::INNER_GAIN_RST;
            r_cfg.stall_speed_min <= fmcp_pkg::STALL_MIN_RST;
            r_cfg.stall_limit     <= fmcp_pkg::STALL_LIMIT_RST;
            r_cfg.err_check_en    <= 1'b1;
            r_cfg.err_drive_en    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fmcp_pkg::CFG_OUTER_GAIN:  r_cfg.outer_gain      <= i_cfg_wdata[9:0];
                fmcp_pkg::CFG_INNER_GAIN:  r_cfg.inner_gain      <= i_cfg_wdata[7:0];
                fmcp_pkg::CFG_STALL_MIN:   r_cfg.stall_speed_min <= i_cfg_wdata[23:0];
                fmcp_pkg::CFG_STALL_LIMIT: r_cfg.stall_limit     <= i_cfg_wdata[15:0];
                fmcp_pkg::CFG_ERR_CHECK:   r_cfg.err_check_en    <= i_cfg_wdata[0];
                fmcp_pkg::CFG_ERR_DRIVE:   r_cfg.err_drive_en    <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign o_ready    = !r_busy;
    assign w_accept   = i_valid && o_ready;
    assign w_uword    = fmcp_pkg::ucode_rom(r_upc);
    assign w_out_free = !r_out_valid || i_ready;
    assign w_emit     = r_busy && (w_uword.uop == fmcp_pkg::UOP_EMIT) && w_out_free;

    assign w_ctrl.load = w_accept;
    assign w_ctrl.uop  = r_busy ? w_uword.uop : fmcp_pkg::UOP_NOP;

    always_comb begin
        n_upc = r_upc + UPC_W'(1);
        case (w_uword.jc)
            fmcp_pkg::JC_GOTO:     n_upc = w_uword.target;
            fmcp_pkg::JC_IF_SPEED: n_upc = w_stat.pos_mode ? r_upc + UPC_W'(1)
                                                           : w_uword.target;
            default:               n_upc = r_upc + UPC_W'(1);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_upc  <= fmcp_pkg::UA_EMIT;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_upc  <= fmcp_pkg::entry_addr(i_op, r_cfg.err_check_en && w_stat.err_latch);
        end else if (r_busy) begin
            if (w_uword.uop == fmcp_pkg::UOP_EMIT) begin
                if (w_out_free) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_upc <= n_upc;
            end
        end
    end

    fmcp_dpath #(
        .AVG_TAPS   (AVG_TAPS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (w_ctrl),
        .i_cfg           (r_cfg),
        .i_encoder_delta (i_encoder_delta),
        .i_position_mode (i_position_mode),
        .i_speed_target  (i_speed_target),
        .i_load_command  (i_load_command),
        .i_mouse_left    (i_mouse_left),
        .i_switch_up     (i_switch_up),
        .i_computer_mode (i_computer_mode),
        .i_step_size     (i_step_size),
        .o_stat          (w_stat),
        .o_drive         (w_drive),
        .o_drive_written (w_written),
        .o_working_flag  (w_working),
        .o_motor_error   (w_error),
        .o_average_speed (w_avg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_drive   <= w_drive;
            r_out_written <= w_written;
            r_out_working <= w_working;
            r_out_error   <= w_error;
            r_out_avg     <= w_avg;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_drive         = r_out_drive;
    assign o_drive_written = r_out_written;
    assign o_working_flag  = r_out_working;
    assign o_motor_error   = r_out_error;
    assign o_average_speed = r_out_avg;

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_drive <= fmcp_pkg::DRIVE_MAX))
        else $error("drive value above its limit");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.err_latch |=> w_stat.err_latch)
        else $error("motor error latch cleared without reset");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (w_uword.uop == fmcp_pkg::UOP_EMIT) && r_out_valid && !i_ready)
        |=> (r_busy && $stable(r_upc)))
        else $error("sequencer left the final step while the output was blocked");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_out_valid && !r_busy))
        else $error("final step did not deliver a result");

endmodule

// File: tb/fmcp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmcp_checker
// Watches the request, result and register-write ports of the feeder motor
// controller. It keeps its own copy of the controller state and registers,
// works out the outputs that each accepted request must produce, and checks
// every accepted result field by field against the oldest outstanding one.
// ----------------------------------------------------------------------------
module fmcp_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fmcp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fmcp_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_valid,
    input  logic                            i_ready_dut,
    input  logic [1:0]                      i_op,
    input  logic signed [15:0]              i_encoder_delta,
    input  logic                            i_position_mode,
    input  logic [23:0]                     i_speed_target,
    input  logic                            i_load_command,
    input  logic                            i_mouse_left,
    input  logic                            i_switch_up,
    input  logic                            i_computer_mode,
    input  logic [15:0]                     i_step_size,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [9:0]                      i_drive,
    input  logic                            i_drive_written,
    input  logic                            i_working_flag,
    input  logic                            i_motor_error,
    input  logic [23:0]                     i_average_speed,
    output int                              o_mismatches,
    output int                              o_outstanding
);

    localparam int          TAPS     = fmcp_pkg::AVG_TAPS_DEF;
    localparam logic [15:0] SLOW_MAX = '1;

    typedef struct packed {
        logic [9:0]  drive;
        logic        written;
        logic        working;
        logic        motor_error;
        logic [23:0] avg;
    } t_feeder_out;

    fmcp_pkg::t_cfg regs;
    logic [23:0]    speed_ring [TAPS];
    int             ring_slot;
    logic [23:0]    avg_q8;
    logic [31:0]    pulse_count;
    logic [31:0]    pulse_goal;
    logic [15:0]    slow_count;
    logic           error_latch;
    logic           working;
    logic [9:0]     drive;

    t_feeder_out outputs_due [$];

    function automatic void clear_state();
        regs.outer_gain      = fmcp_pkg::OUTER_GAIN_RST;
        regs.inner_gain      = fmcp_pkg::INNER_GAIN_RST;
        regs.stall_speed_min = fmcp_pkg::STALL_MIN_RST;
        regs.stall_limit     = fmcp_pkg::STALL_LIMIT_RST;
        regs.err_check_en    = 1'b1;
        regs.err_drive_en    = 1'b0;
        for (int k = 0; k < TAPS; k++) begin
            speed_ring[k] = '0;
        end
        ring_slot   = 0;
        avg_q8      = '0;
        pulse_count = '0;
        pulse_goal  = '0;
        slow_count  = '0;
        error_latch = 1'b0;
        working     = 1'b1;
        drive       = '0;
    endfunction

    function automatic void write_reg(input logic [fmcp_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [fmcp_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            fmcp_pkg::CFG_OUTER_GAIN:  regs.outer_gain      = data[9:0];
            fmcp_pkg::CFG_INNER_GAIN:  regs.inner_gain      = data[7:0];
            fmcp_pkg::CFG_STALL_MIN:   regs.stall_speed_min = data[23:0];
            fmcp_pkg::CFG_STALL_LIMIT: regs.stall_limit     = data[15:0];
            fmcp_pkg::CFG_ERR_CHECK:   regs.err_check_en    = data[0];
            fmcp_pkg::CFG_ERR_DRIVE:   regs.err_drive_en    = data[0];
            default: ;
        endcase
    endfunction

    // One control tick: new speed sample, ring average, setpoint and drive.
    function automatic void control_tick();
        longint mag;
        longint sum;
        longint avg_l;
        longint gap_l;
        longint gain_l;
        longint num;
        longint setp;
        longint delta;
        longint power;
        logic signed [31:0] gap;
        logic gate;

        mag = (i_encoder_delta < 0) ? -longint'(i_encoder_delta) : longint'(i_encoder_delta);
        if (mag > 32767) mag = 32767;
        speed_ring[ring_slot] = 24'((mag * 25600) / 520);
        sum = 0;
        for (int k = 0; k < TAPS; k++) begin
            sum += speed_ring[k];
        end
        avg_q8    = 24'(sum / TAPS);
        ring_slot = (ring_slot + 1) % TAPS;
        avg_l     = avg_q8;

        if (i_position_mode) begin
            pulse_count = pulse_count + 32'(mag);
            gap    = pulse_goal - pulse_count;
            gap_l  = gap;
            gain_l = regs.outer_gain;
            num    = gap_l * gain_l * 256;
            setp   = num / 1000;
            if ((num % 1000 != 0) && (num < 0)) setp -= 1;
            if (setp > 256) setp = 256;
            delta = setp - avg_l;
        end else begin
            delta   = longint'(i_speed_target) - avg_l;
            working = (delta > 256 && i_load_command && (i_mouse_left || i_switch_up))
                      ? 1'b0 : 1'b1;
        end

        if (delta < 0) delta = 0;
        gain_l = regs.inner_gain;
        power  = (delta * 5 * gain_l) / 256;
        if (power > 600) power = 600;
        if (!i_position_mode) begin
            gate = i_computer_mode ? (i_load_command && i_mouse_left)
                                   : (i_load_command && i_switch_up);
            if (!gate) power = 0;
        end
        drive = 10'(power);
    endfunction

    function automatic t_feeder_out apply_request();
        t_feeder_out res;
        logic wrote;

        wrote = 1'b0;
        case (i_op)
            fmcp_pkg::OP_TICK: begin
                if (regs.err_check_en && error_latch) begin
                    if (regs.err_drive_en) begin
                        drive = fmcp_pkg::DRIVE_ERROR;
                        wrote = 1'b1;
                    end
                end else begin
                    control_tick();
                    wrote = 1'b1;
                end
            end
            fmcp_pkg::OP_STEP: begin
                pulse_count = pulse_goal;
                pulse_goal  = pulse_goal + 32'(i_step_size);
            end
            fmcp_pkg::OP_STALL: begin
                if (avg_q8 < regs.stall_speed_min) begin
                    if (slow_count < SLOW_MAX) slow_count = slow_count + 1'b1;
                end else begin
                    slow_count = '0;
                end
                if (slow_count >= regs.stall_limit) begin
                    slow_count  = '0;
                    error_latch = 1'b1;
                end
            end
            default: ;
        endcase

        res.drive       = drive;
        res.written     = wrote;
        res.working     = working;
        res.motor_error = error_latch;
        res.avg         = avg_q8;
        return res;
    endfunction

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_feeder_out due;
        if (!i_rst_n) begin
            clear_state();
            outputs_due.delete();
        end else begin
            if (i_cfg_we) write_reg(i_cfg_idx, i_cfg_wdata);
            if (i_out_valid && i_out_ready) begin
                if (outputs_due.size() == 0) begin
                    $error("result accepted with no request outstanding");
                    o_mismatches++;
                end else begin
                    due = outputs_due.pop_front();
                    compare_field("drive", due.drive, i_drive);
                    compare_field("drive_written", due.written, i_drive_written);
                    compare_field("working_flag", due.working, i_working_flag);
                    compare_field("motor_error", due.motor_error, i_motor_error);
                    compare_field("average_speed", due.avg, i_average_speed);
                end
            end
            if (i_valid && i_ready_dut) outputs_due.push_back(apply_request());
        end
        o_outstanding <= outputs_due.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the feeder motor cascade controller: a short directed set of
// requests, then random phases under several register settings, with random
// idling on both channels. The checker beside the block does all prediction
// and comparison; this module drives the ports and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         WATCHDOG_LIMIT = 5000;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [fmcp_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [fmcp_pkg::CFG_DATA_W-1:0] i_cfg_wdata;
    logic                            i_valid;
    logic                            o_ready;
    logic [1:0]                      i_op;
    logic signed [15:0]              i_encoder_delta;
    logic                            i_position_mode;
    logic [23:0]                     i_speed_target;
    logic                            i_load_command;
    logic                            i_mouse_left;
    logic                            i_switch_up;
    logic                            i_computer_mode;
    logic [15:0]                     i_step_size;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic [9:0]                      o_drive;
    logic                            o_drive_written;
    logic                            o_working_flag;
    logic                            o_motor_error;
    logic [23:0]                     o_average_speed;

    int mismatches;
    int outstanding;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;
    logic loop_position = 1'b0;

    always #10 i_clk = ~i_clk;

    feeder_motor_cascade_p_control DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_encoder_delta (i_encoder_delta),
        .i_position_mode (i_position_mode),
        .i_speed_target  (i_speed_target),
        .i_load_command  (i_load_command),
        .i_mouse_left    (i_mouse_left),
        .i_switch_up     (i_switch_up),
        .i_computer_mode (i_computer_mode),
        .i_step_size     (i_step_size),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_drive         (o_drive),
        .o_drive_written (o_drive_written),
        .o_working_flag  (o_working_flag),
        .o_motor_error   (o_motor_error),
        .o_average_speed (o_average_speed)
    );

    fmcp_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .i_ready_dut     (o_ready),
        .i_op            (i_op),
        .i_encoder_delta (i_encoder_delta),
        .i_position_mode (i_position_mode),
        .i_speed_target  (i_speed_target),
        .i_load_command  (i_load_command),
        .i_mouse_left    (i_mouse_left),
        .i_switch_up     (i_switch_up),
        .i_computer_mode (i_computer_mode),
        .i_step_size     (i_step_size),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_drive         (o_drive),
        .i_drive_written (o_drive_written),
        .i_working_flag  (o_working_flag),
        .i_motor_error   (o_motor_error),
        .i_average_speed (o_average_speed),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL feeder_motor_cascade_p_control");
            $finish;
        end
    end

    // Valid is left high after acceptance so that back-to-back requests never
    // lower and raise it within one time step.
    task automatic send_req(input logic [1:0] op, input logic [15:0] enc,
                            input logic pos, input logic [23:0] tgt,
                            input logic cmd, input logic ml, input logic sw,
                            input logic cm, input logic [15:0] step);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_op            <= op;
        i_encoder_delta <= enc;
        i_position_mode <= pos;
        i_speed_target  <= tgt;
        i_load_command  <= cmd;
        i_mouse_left    <= ml;
        i_switch_up     <= sw;
        i_computer_mode <= cm;
        i_step_size     <= step;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic finish_phase();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic put_reg(input fmcp_pkg::t_cfg_idx idx,
                           input logic [fmcp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [9:0] og, input logic [7:0] ig,
                                input logic [23:0] smin, input logic [15:0] slim,
                                input logic chk, input logic drv);
        put_reg(fmcp_pkg::CFG_OUTER_GAIN, {14'd0, og});
        put_reg(fmcp_pkg::CFG_INNER_GAIN, {16'd0, ig});
        put_reg(fmcp_pkg::CFG_STALL_MIN, smin);
        put_reg(fmcp_pkg::CFG_STALL_LIMIT, {8'd0, slim});
        put_reg(fmcp_pkg::CFG_ERR_CHECK, {23'd0, chk});
        put_reg(fmcp_pkg::CFG_ERR_DRIVE, {23'd0, drv});
        i_cfg_we <= 1'b0;
    endtask

    // Mostly plausible encoder counts and targets so that the loops settle in
    // range, with full-width values mixed in.
    task automatic run_random(input int count);
        int r;
        logic [1:0]  op;
        logic [15:0] enc;
        logic [23:0] tgt;
        logic [15:0] step;
        for (int n = 0; n < count; n++) begin
            r  = $urandom_range(99);
            op = (r < 62) ? fmcp_pkg::OP_TICK
               : (r < 76) ? fmcp_pkg::OP_STEP
               : (r < 95) ? fmcp_pkg::OP_STALL : OP_UNUSED;
            case ($urandom_range(3))
                0: enc = 16'($urandom_range(400) - 200);
                1: enc = 16'($urandom_range(6000) - 3000);
                2: enc = 16'($urandom);
                default: enc = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            endcase
            tgt  = ($urandom_range(3) != 0) ? 24'($urandom_range(12000)) : 24'($urandom);
            step = ($urandom_range(3) != 0) ? 16'($urandom_range(3000)) : 16'($urandom);
            if ($urandom_range(9) == 0) loop_position = ~loop_position;
            send_req(op, enc, loop_position, tgt, $urandom_range(3) != 0,
                     1'($urandom), 1'($urandom), 1'($urandom), step);
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_wdata     <= '0;
        i_valid         <= 1'b0;
        i_op            <= fmcp_pkg::OP_TICK;
        i_encoder_delta <= '0;
        i_position_mode <= 1'b0;
        i_speed_target  <= '0;
        i_load_command  <= 1'b0;
        i_mouse_left    <= 1'b0;
        i_switch_up     <= 1'b0;
        i_computer_mode <= 1'b0;
        i_step_size     <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 9;
        recv_idle_pct = 79;

        // Directed requests under the reset register values.
        send_req(fmcp_pkg::OP_TICK, 16'h0000, 1'b0, 24'h000000,
                 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_req(fmcp_pkg::OP_TICK, 16'h7FFF, 1'b0, 24'hFFFFFF,
                 1'b1, 1'b1, 1'b1, 1'b1, 16'h0000);
        send_req(fmcp_pkg::OP_TICK, 16'h8000, 1'b0, 24'hFFFFFF,
                 1'b1, 1'b0, 1'b1, 1'b0, 16'h0000);
        send_req(fmcp_pkg::OP_TICK, 16'hFFFF, 1'b0, 24'd1000,
                 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_req(fmcp_pkg::OP_TICK, 16'd100, 1'b0, 24'd20000,
                 1'b1, 1'b1, 1'b0, 1'b1, 16'h0000);
        send_req(fmcp_pkg::OP_TICK, 16'd100, 1'b0, 24'd20000,
                 1'b1, 1'b0, 1'b1, 1'b1, 16'h0000);
        send_req(fmcp_pkg::OP_TICK, 16'd5, 1'b0, 24'h000000,
                 1'b1, 1'b1, 1'b1, 1'b0, 16'h0000);
        send_req(fmcp_pkg::OP_STEP, 16'h0000, 1'b1, 24'h000000,
                 1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF);
        send_req(fmcp_pkg::OP_TICK, 16'd50, 1'b1, 24'h000000,
                 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_req(fmcp_pkg::OP_TICK, 16'h7FFF, 1'b1, 24'hFFFFFF,
                 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_req(fmcp_pkg::OP_TICK, 16'h7FFF, 1'b1, 24'h000000,
                 1'b1, 1'b1, 1'b1, 1'b1, 16'h0000);
        send_req(fmcp_pkg::OP_TICK, 16'h8000, 1'b1, 24'h000000,
                 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_req(fmcp_pkg::OP_STEP, 16'h0000, 1'b1, 24'h000000,
                 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_req(fmcp_pkg::OP_STEP, 16'h0000, 1'b1, 24'h000000,
                 1'b0, 1'b0, 1'b0, 1'b0, 16'd12345);
        send_req(fmcp_pkg::OP_TICK, 16'h0001, 1'b1, 24'h000000,
                 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_req(fmcp_pkg::OP_STALL, 16'h0000, 1'b0, 24'h000000,
                 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000);
        repeat (5) begin
            send_req(fmcp_pkg::OP_TICK, 16'h0000, 1'b0, 24'd300,
                     1'b1, 1'b1, 1'b1, 1'b0, 16'h0000);
        end
        send_req(fmcp_pkg::OP_STALL, 16'h0000, 1'b0, 24'h000000,
                 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_req(OP_UNUSED, 16'hFFFF, 1'b1, 24'hFFFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF);
        finish_phase();

        // Highest gains; nothing is ever slow, so no error can latch yet.
        program_regs(10'd1023, 8'd255, 24'd0, 16'hFFFF, 1'b1, 1'b0);
        run_random(350);
        finish_phase();

        send_idle_pct = 79;
        recv_idle_pct = 9;
        program_regs(10'($urandom_range(1023)), 8'($urandom_range(255)),
                     24'($urandom_range(3000)), 16'hFFFF, 1'b1, 1'b1);
        run_random(350);
        finish_phase();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Short stall limit with ticks still running while the error latches.
        program_regs(10'd0, 8'd0, 24'd2000, 16'd4, 1'b0, 1'b1);
        run_random(150);
        finish_phase();

        // A zero stall limit raises the error on every check.
        program_regs(10'($urandom_range(1023)), 8'($urandom_range(255)),
                     24'hFFFFFF, 16'd0, 1'b1, 1'b1);
        run_random(100);
        finish_phase();

        program_regs(10'd180, 8'd35, 24'd256, 16'd1, 1'b1, 1'b0);
        run_random(100);
        finish_phase();

        program_regs(10'($urandom_range(1023)), 8'($urandom_range(255)),
                     24'($urandom), 16'($urandom), 1'b0, 1'b0);
        run_random(100);
        finish_phase();

        repeat (24) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS feeder_motor_cascade_p_control");
        end else begin
            $display("FAIL feeder_motor_cascade_p_control");
        end
        $finish;
    end

endmodule
